### rtl/okl_pkg.sv
// ----------------------------------------------------------------------------
// okl_pkg
// shared constants, opcodes and item types for the ordered key list engine
// ----------------------------------------------------------------------------
package okl_pkg;

   // list geometry
   localparam int DEPTH     = 16;
   localparam int KEY_CHARS = 8;

   // fixed field widths
   localparam int KEY_W     = 64;
   localparam int OP_W      = 3;
   localparam int POS_W     = 5;
   localparam int OUT_CNT_W = 5;

   // derived widths
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // only the low KEY_CHARS bytes of a key are kept
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_CHARS);

   // opcodes
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_RMKEY  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_RMPOS  = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
   localparam logic [OP_W-1:0] OP_RMMIN  = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [POS_W-1:0] position;
      logic [KEY_W-1:0] key_in;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [KEY_W-1:0]     key_out;
      logic [OUT_CNT_W-1:0] entry_count;
      logic                 is_empty;
      logic                 is_full;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            count_zero;
      logic            scan_last;
      logic            scan_hit;
   } sts_type;

endpackage

### rtl/ordered_key_list_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_key_list_engine_core
// ordered list of up to DEPTH packed keys with positional and keyed ops
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; busy then stays high
// until the item is done. each item gives exactly one result, shown on rsp_data
// for a single cycle with rsp_valid high; the receiver cannot stall, so it must
// take the result in that cycle. append, read, remove at position, insert and
// clear go through load, decode and execute. remove key and remove min also
// run a scan between decode and execute over the stored entries through one
// read port, one entry a cycle, up to the count; a key remove stops at the
// first match. busy drops in the cycle the result is shown, so the next item
// can be taken right then. keys are compared as unsigned numbers; only the
// low 8*KEY_CHARS bits are stored.
// ----------------------------------------------------------------------------
module ordered_key_list_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  okl_pkg::req_type req_data,
   output logic             rsp_valid,
   output okl_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   okl_pkg::cmd_type cmd;
   okl_pkg::sts_type sts;

   // sequencer
   okl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // entry table, scan unit and result register
   okl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/okl_datapath.sv
// ----------------------------------------------------------------------------
// okl_datapath
// entry table, count, scan unit and result register of the key list
// ----------------------------------------------------------------------------
module okl_datapath (
   input  logic             clock,
   input  logic             reset,
   input  okl_pkg::req_type req_data,
   input  okl_pkg::cmd_type cmd,
   output okl_pkg::sts_type sts,
   output logic             rsp_valid,
   output okl_pkg::rsp_type rsp_data
);

   okl_pkg::req_type                 req_ff;
   logic [okl_pkg::KEY_W-1:0]        entries_ff [okl_pkg::DEPTH];
   logic [okl_pkg::CNT_W-1:0]        count_ff;
   logic [okl_pkg::CNT_W-1:0]        count_in;
   logic [okl_pkg::IDX_W-1:0]        scan_idx_ff;
   logic [okl_pkg::IDX_W-1:0]        tgt_ff;
   logic                             found_ff;
   logic [okl_pkg::KEY_W-1:0]        min_key_ff;
   okl_pkg::rsp_type                 rsp_ff;
   logic                             rsp_valid_ff;

   logic [okl_pkg::CMP_W-1:0]        pos_ext;
   logic [okl_pkg::CMP_W-1:0]        cnt_ext;
   logic [okl_pkg::CMP_W-1:0]        pos_m1;
   logic [okl_pkg::CMP_W-1:0]        ins_ext;
   logic                             pos_valid;
   logic                             not_full;
   logic [okl_pkg::IDX_W-1:0]        pos_idx;
   logic [okl_pkg::IDX_W-1:0]        ins_idx;
   logic [okl_pkg::IDX_W-1:0]        app_idx;
   logic [okl_pkg::IDX_W-1:0]        rd_idx;
   logic [okl_pkg::KEY_W-1:0]        rd_key;
   logic                             do_app;
   logic                             do_del;
   logic                             do_ins;
   logic                             ok_c;
   logic [okl_pkg::KEY_W-1:0]        kout_c;

   // position decode
   assign pos_ext   = okl_pkg::CMP_W'(req_ff.position);
   assign cnt_ext   = okl_pkg::CMP_W'(count_ff);
   assign pos_m1    = pos_ext - okl_pkg::CMP_W'(1);
   assign pos_valid = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign not_full  = (count_ff != okl_pkg::CNT_W'(okl_pkg::DEPTH));
   assign pos_idx   = okl_pkg::IDX_W'(pos_m1);
   assign ins_ext   = (pos_m1 > cnt_ext) ? cnt_ext : pos_m1;
   assign ins_idx   = okl_pkg::IDX_W'(ins_ext);
   assign app_idx   = okl_pkg::IDX_W'(count_ff);

   // single read port: scan pointer while scanning, else the target entry
   always_comb begin
      if (cmd.scan_step) begin
         rd_idx = scan_idx_ff;
      end else if (req_ff.opcode == okl_pkg::OP_READ || req_ff.opcode == okl_pkg::OP_RMPOS) begin
         rd_idx = pos_idx;
      end else begin
         rd_idx = tgt_ff;
      end
   end

   assign rd_key = entries_ff[rd_idx];

   assign sts.op         = req_ff.opcode;
   assign sts.count_zero = (count_ff == '0);
   assign sts.scan_last  = ((okl_pkg::CNT_W'(scan_idx_ff) + okl_pkg::CNT_W'(1)) == count_ff);
   assign sts.scan_hit   = (req_ff.opcode == okl_pkg::OP_RMKEY) && (rd_key == req_ff.key_in);

   // operation decode
   always_comb begin
      ok_c     = 1'b0;
      kout_c   = '0;
      count_in = count_ff;
      do_app   = 1'b0;
      do_del   = 1'b0;
      do_ins   = 1'b0;
      case (req_ff.opcode)
         okl_pkg::OP_APPEND: begin
            if (not_full) begin
               ok_c     = 1'b1;
               do_app   = 1'b1;
               count_in = count_ff + okl_pkg::CNT_W'(1);
            end
         end
         okl_pkg::OP_RMKEY: begin
            if (found_ff) begin
               ok_c     = 1'b1;
               kout_c   = rd_key;
               do_del   = 1'b1;
               count_in = count_ff - okl_pkg::CNT_W'(1);
            end
         end
         okl_pkg::OP_READ: begin
            if (pos_valid) begin
               ok_c   = 1'b1;
               kout_c = rd_key;
            end
         end
         okl_pkg::OP_RMPOS: begin
            if (pos_valid) begin
               ok_c     = 1'b1;
               kout_c   = rd_key;
               do_del   = 1'b1;
               count_in = count_ff - okl_pkg::CNT_W'(1);
            end
         end
         okl_pkg::OP_INSERT: begin
            if (pos_ext != '0 && not_full) begin
               ok_c     = 1'b1;
               do_ins   = 1'b1;
               count_in = count_ff + okl_pkg::CNT_W'(1);
            end
         end
         okl_pkg::OP_RMMIN: begin
            if (count_ff != '0) begin
               ok_c     = 1'b1;
               kout_c   = rd_key;
               do_del   = 1'b1;
               count_in = count_ff - okl_pkg::CNT_W'(1);
            end
         end
         okl_pkg::OP_CLEAR: begin
            ok_c     = 1'b1;
            count_in = '0;
         end
         default: begin
            ok_c = 1'b0;
         end
      endcase
   end

   // per-entry shift network
   for (genvar g = 0; g < okl_pkg::DEPTH; g++) begin : g_entry
      logic [okl_pkg::KEY_W-1:0] upper;
      logic [okl_pkg::KEY_W-1:0] lower;
      logic [okl_pkg::KEY_W-1:0] entry_in;

      if (g < okl_pkg::DEPTH - 1) begin : g_up
         assign upper = entries_ff[g + 1];
      end else begin : g_top
         assign upper = entries_ff[g];
      end

      if (g > 0) begin : g_lo
         assign lower = entries_ff[g - 1];
      end else begin : g_bot
         assign lower = entries_ff[g];
      end

      always_comb begin
         entry_in = entries_ff[g];
         if (cmd.exec) begin
            if (do_del && okl_pkg::IDX_W'(g) >= rd_idx) begin
               entry_in = upper;
            end
            if (do_ins && okl_pkg::IDX_W'(g) > ins_idx) begin
               entry_in = lower;
            end
            if (do_ins && okl_pkg::IDX_W'(g) == ins_idx) begin
               entry_in = req_ff.key_in;
            end
            if (do_app && okl_pkg::IDX_W'(g) == app_idx) begin
               entry_in = req_ff.key_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[g] <= entry_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         rsp_valid_ff <= cmd.exec;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end
         if (cmd.scan_init) begin
            scan_idx_ff <= '0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + okl_pkg::IDX_W'(1);
            if (sts.scan_hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.exec) begin
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff.opcode   <= req_data.opcode;
         req_ff.position <= req_data.position;
         req_ff.key_in   <= req_data.key_in & okl_pkg::KEY_MASK;
      end
      if (cmd.scan_step) begin
         if (sts.scan_hit) begin
            tgt_ff <= scan_idx_ff;
         end
         if (req_ff.opcode == okl_pkg::OP_RMMIN &&
             (scan_idx_ff == '0 || rd_key < min_key_ff)) begin
            min_key_ff <= rd_key;
            tgt_ff     <= scan_idx_ff;
         end
      end
      if (cmd.exec) begin
         rsp_ff.ok          <= ok_c;
         rsp_ff.key_out     <= kout_c;
         rsp_ff.entry_count <= okl_pkg::OUT_CNT_W'(count_in);
         rsp_ff.is_empty    <= (count_in == '0);
         rsp_ff.is_full     <= (count_in == okl_pkg::CNT_W'(okl_pkg::DEPTH));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= okl_pkg::CNT_W'(okl_pkg::DEPTH))
      else $error("entry count above depth");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |-> rsp_ff.key_out == '0)
      else $error("refused item carries a key");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.is_empty == (count_ff == '0))
      else $error("empty flag disagrees with count");
`endif

endmodule

### rtl/okl_ctrl.sv
// ----------------------------------------------------------------------------
// okl_ctrl
// sequencer: accept, decode, key scan and execute
// ----------------------------------------------------------------------------
module okl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  okl_pkg::sts_type sts,
   output okl_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_EXEC   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       is_scan_op;

   assign is_scan_op = (sts.op == okl_pkg::OP_RMKEY) || (sts.op == okl_pkg::OP_RMMIN);
   assign busy       = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (is_scan_op && !sts.count_zero) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit || sts.scan_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

   a_scan_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> sts.op == okl_pkg::OP_RMKEY || sts.op == okl_pkg::OP_RMMIN)
      else $error("scan entered for an op that needs none");

   a_exec_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> !busy)
      else $error("execute did not return to idle");
`endif

endmodule
